// ----- rtl/rpeg_pkg.sv -----
// ----------------------------------------------------------------------------
// rpeg_pkg
// Shared types, constants and helpers of the regular polygon edge generator.
// ----------------------------------------------------------------------------
package rpeg_pkg;

	localparam int SIDE_W   = 7;
	localparam int COORD_W  = 9;
	localparam int RADIUS_W = 8;
	localparam int TRIG_W   = 17;
	localparam int PADDR_W  = 3;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd100;
	localparam logic                REG_RADIUS   = 1'b0;

	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
	localparam logic [16:0] TWO_PI_HI = 17'h1921F;
	localparam logic [15:0] TWO_PI_LO = 16'hB544;

	localparam int          N_TERMS  = 11;
	localparam logic [3:0]  SIN_LAST = 4'd4;
	localparam logic [3:0]  COS_LAST = 4'd10;

	// ceil(2^s / d) reciprocals of the series divisors, sine terms then cosine terms
	localparam logic [31:0] RECIP [0:N_TERMS-1] = '{
		32'(((64'd1 << 37) + 64'd109) / 64'd110),
		32'(((64'd1 << 37) + 64'd71) / 64'd72),
		32'(((64'd1 << 36) + 64'd41) / 64'd42),
		32'(((64'd1 << 35) + 64'd19) / 64'd20),
		32'(((64'd1 << 33) + 64'd5) / 64'd6),
		32'(((64'd1 << 38) + 64'd131) / 64'd132),
		32'(((64'd1 << 37) + 64'd89) / 64'd90),
		32'(((64'd1 << 36) + 64'd55) / 64'd56),
		32'(((64'd1 << 35) + 64'd29) / 64'd30),
		32'(((64'd1 << 34) + 64'd11) / 64'd12),
		32'(((64'd1 << 31) + 64'd1) / 64'd2)
	};

	localparam logic [5:0] RSHIFT [0:N_TERMS-1] = '{
		6'd37, 6'd37, 6'd36, 6'd35, 6'd33,
		6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd31
	};

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

	typedef enum logic [1:0] {B_IDLE, B_FIRST, B_NEXT} back_state_t;

	typedef enum logic [3:0] {
		V_IDLE, V_ANG_HI, V_ANG_LO, V_SQR, V_SMUL, V_SDIV, V_SFIN,
		V_CMUL, V_CDIV, V_XSC, V_YSC
	} vtx_state_t;

	typedef struct packed {
		logic                      done;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} vtx_res_t;

	function automatic logic [TRIG_W-1:0] q30_to_q16(input logic [30:0] v);
		logic [31:0] s;
		s = {1'b0, v} + 32'd8192;
		return TRIG_W'(s >> 14);
	endfunction

endpackage

// ----- rtl/rpeg_front.sv -----
// ----------------------------------------------------------------------------
// rpeg_front
// Accepts side counts, saturates them and divides out the angle step.
// ----------------------------------------------------------------------------
module rpeg_front #(
	parameter int MAX_SIDES  = 64,
	parameter int ANGLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [rpeg_pkg::SIDE_W-1:0]            sides,
	output logic                                   busy,
	output logic                                   push,
	output logic [rpeg_pkg::SIDE_W+ANGLE_BITS-1:0] push_data,
	input  logic                                   full
);
	import rpeg_pkg::*;

	localparam int CNT_W = $clog2(ANGLE_BITS + 2);

	front_state_t          state_q, state_n;
	logic [SIDE_W-1:0]     div_q;
	logic [SIDE_W-1:0]     rem_q;
	logic [ANGLE_BITS:0]   dvd_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SIDE_W-1:0]     sat;
	logic [SIDE_W:0]       rem_sh;
	logic [SIDE_W:0]       rem_n;
	logic                  ge;
	logic                  accept;

	assign sat    = (sides > SIDE_W'(MAX_SIDES)) ? SIDE_W'(MAX_SIDES) : sides;
	assign accept = start && (state_q == F_IDLE);
	assign rem_sh = {rem_q, dvd_q[ANGLE_BITS]};
	assign ge     = rem_sh >= {1'b0, div_q};
	assign rem_n  = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	assign busy   = (state_q != F_IDLE);
	assign push_data = {div_q, dvd_q[ANGLE_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		push    = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				if (accept && sat != '0) state_n = F_DIV;
			end
			F_DIV: begin
				if (cnt_q == CNT_W'(ANGLE_BITS)) state_n = F_PUSH;
			end
			F_PUSH: begin
				push = !full;
				if (!full) state_n = F_IDLE;
			end
			default: state_n = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			div_q <= sat;
			rem_q <= '0;
			dvd_q <= (ANGLE_BITS+1)'(1) << ANGLE_BITS | (ANGLE_BITS+1)'(sat >> 1);
			cnt_q <= '0;
		end else if (state_q == F_DIV) begin
			rem_q <= rem_n[SIDE_W-1:0];
			dvd_q <= {dvd_q[ANGLE_BITS-1:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

// ----- rtl/rpeg_fifo.sv -----
// ----------------------------------------------------------------------------
// rpeg_fifo
// Two-entry queue of polygon jobs between front and back.
// ----------------------------------------------------------------------------
module rpeg_fifo #(
	parameter int W = 23
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);
	logic [W-1:0] mem [0:1];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

endmodule

// ----- rtl/rpeg_vertex.sv -----
// ----------------------------------------------------------------------------
// rpeg_vertex
// Sequenced vertex unit: angle to radians, sine and cosine series, scaling,
// all on one shared multiplier.
// ----------------------------------------------------------------------------
module rpeg_vertex #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [ANGLE_BITS-1:0]           angle,
	input  logic [rpeg_pkg::RADIUS_W-1:0]   radius,
	output rpeg_pkg::vtx_res_t              res
);
	import rpeg_pkg::*;

	localparam int FA_W  = ANGLE_BITS - 2;
	localparam int ACC_W = FA_W + 17;
	localparam logic [FA_W-1:0] EIGHTH  = FA_W'(1) << (FA_W - 1);
	localparam logic [FA_W:0]   QUARTER = (FA_W+1)'(1) << FA_W;

	vtx_state_t         state_q, state_n;
	logic [1:0]         quad_q;
	logic               swap_q;
	logic [FA_W-1:0]    g_q;
	logic [ACC_W-1:0]   acc_q;
	logic [29:0]        x_q;
	logic [29:0]        x2_q;
	logic [30:0]        t_q;
	logic [29:0]        v_q;
	logic [3:0]         lvl_q;
	logic [TRIG_W-1:0]  sin_q;
	logic [COORD_W-1:0] vx_q;
	logic [COORD_W-1:0] vy_q;
	logic               done_q;

	logic [FA_W-1:0]    fa;
	logic               swap;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        prod;
	logic [TRIG_W-1:0]  cos16;
	logic [TRIG_W-1:0]  xmag;
	logic [TRIG_W-1:0]  ymag;
	logic               use_sin_x;
	logic [7:0]         mag8;
	logic [COORD_W-1:0] coord;
	logic               neg;

	assign fa        = angle[FA_W-1:0];
	assign swap      = fa > EIGHTH;
	assign cos16     = q30_to_q16(t_q);
	assign use_sin_x = swap_q ^ quad_q[0];
	assign xmag      = use_sin_x ? sin_q : cos16;
	assign ymag      = use_sin_x ? cos16 : sin_q;
	assign prod      = 64'(mul_a) * 64'(mul_b);
	assign mag8      = prod[23:16];
	assign neg       = (state_q == V_XSC) ? (quad_q[0] ^ quad_q[1]) : quad_q[1];
	assign coord     = neg ? COORD_W'(-{1'b0, mag8}) : {1'b0, mag8};
	assign res       = '{done: done_q, x: vx_q, y: vy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= V_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= (state_q == V_YSC);
		end
	end

	always_comb begin
		state_n = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			V_IDLE: begin
				if (start) state_n = V_ANG_HI;
			end
			V_ANG_HI: begin
				mul_a   = 32'(g_q);
				mul_b   = 32'(TWO_PI_HI);
				state_n = V_ANG_LO;
			end
			V_ANG_LO: begin
				mul_a   = 32'(g_q);
				mul_b   = 32'(TWO_PI_LO);
				state_n = V_SQR;
			end
			V_SQR: begin
				mul_a   = 32'(x_q);
				mul_b   = 32'(x_q);
				state_n = V_SMUL;
			end
			V_SMUL, V_CMUL: begin
				mul_a   = 32'(x2_q);
				mul_b   = 32'(t_q);
				state_n = (state_q == V_SMUL) ? V_SDIV : V_CDIV;
			end
			V_SDIV: begin
				mul_a   = 32'(v_q);
				mul_b   = RECIP[lvl_q];
				state_n = (lvl_q == SIN_LAST) ? V_SFIN : V_SMUL;
			end
			V_SFIN: begin
				mul_a   = 32'(x_q);
				mul_b   = 32'(t_q);
				state_n = V_CMUL;
			end
			V_CDIV: begin
				mul_a   = 32'(v_q);
				mul_b   = RECIP[lvl_q];
				state_n = (lvl_q == COS_LAST) ? V_XSC : V_CMUL;
			end
			V_XSC: begin
				mul_a   = 32'(radius);
				mul_b   = 32'(xmag);
				state_n = V_YSC;
			end
			V_YSC: begin
				mul_a   = 32'(radius);
				mul_b   = 32'(ymag);
				state_n = V_IDLE;
			end
			default: state_n = V_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			V_IDLE: begin
				if (start) begin
					quad_q <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
					swap_q <= swap;
					g_q    <= swap ? FA_W'(QUARTER - {1'b0, fa}) : fa;
				end
			end
			V_ANG_HI: acc_q <= ACC_W'(prod);
			V_ANG_LO: x_q <= 30'(((64'(acc_q) << 16) + prod) >> ANGLE_BITS);
			V_SQR: begin
				x2_q  <= 30'(prod >> 30);
				t_q   <= ONE_Q30;
				lvl_q <= '0;
			end
			V_SMUL, V_CMUL: v_q <= 30'(prod >> 30);
			V_SDIV, V_CDIV: begin
				t_q   <= ONE_Q30 - 31'(prod >> RSHIFT[lvl_q]);
				lvl_q <= lvl_q + 1'b1;
			end
			V_SFIN: begin
				sin_q <= q30_to_q16(31'(prod >> 30));
				t_q   <= ONE_Q30;
			end
			V_XSC: vx_q <= coord;
			V_YSC: vy_q <= coord;
			default: ;
		endcase
	end

endmodule

// ----- rtl/rpeg_back.sv -----
// ----------------------------------------------------------------------------
// rpeg_back
// Walks the vertices of one polygon job and emits its segments.
// ----------------------------------------------------------------------------
module rpeg_back #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [rpeg_pkg::RADIUS_W-1:0]          radius,
	input  logic                                   empty,
	output logic                                   pop,
	input  logic [rpeg_pkg::SIDE_W+ANGLE_BITS-1:0] pop_data,
	output logic                                   valid,
	output logic signed [rpeg_pkg::COORD_W-1:0]    x_start,
	output logic signed [rpeg_pkg::COORD_W-1:0]    y_start,
	output logic signed [rpeg_pkg::COORD_W-1:0]    x_end,
	output logic signed [rpeg_pkg::COORD_W-1:0]    y_end,
	output logic                                   last
);
	import rpeg_pkg::*;

	back_state_t               state_q, state_n;
	logic [SIDE_W-1:0]         n_q;
	logic [SIDE_W-1:0]         k_q;
	logic [ANGLE_BITS-1:0]     step_q;
	logic [ANGLE_BITS-1:0]     ang_q;
	logic signed [COORD_W-1:0] xs_q;
	logic signed [COORD_W-1:0] ys_q;
	logic                      valid_q;
	logic                      last_q;
	logic                      vstart;
	logic [ANGLE_BITS-1:0]     vangle;
	logic                      emit;
	vtx_res_t                  vres;

	rpeg_vertex #(.ANGLE_BITS(ANGLE_BITS)) u_vertex (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (vstart),
		.angle  (vangle),
		.radius (radius),
		.res    (vres)
	);

	assign emit    = (state_q == B_NEXT) && vres.done;
	assign valid   = valid_q;
	assign last    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			valid_q <= emit;
			last_q  <= emit && (k_q == n_q);
		end
	end

	always_comb begin
		state_n = state_q;
		pop     = 1'b0;
		vstart  = 1'b0;
		vangle  = ang_q + step_q;
		unique case (state_q)
			B_IDLE: begin
				vangle = pop_data[ANGLE_BITS-1:0];
				if (!empty) begin
					pop     = 1'b1;
					vstart  = 1'b1;
					state_n = B_FIRST;
				end
			end
			B_FIRST: begin
				if (vres.done) begin
					vstart  = 1'b1;
					state_n = B_NEXT;
				end
			end
			B_NEXT: begin
				if (vres.done) begin
					if (k_q == n_q) state_n = B_IDLE;
					else vstart = 1'b1;
				end
			end
			default: state_n = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			n_q    <= pop_data[SIDE_W+ANGLE_BITS-1:ANGLE_BITS];
			step_q <= pop_data[ANGLE_BITS-1:0];
			ang_q  <= pop_data[ANGLE_BITS-1:0];
			k_q    <= SIDE_W'(1);
		end
		if (state_q == B_FIRST && vres.done) begin
			xs_q  <= vres.x;
			ys_q  <= vres.y;
			ang_q <= vangle;
		end
		if (emit) begin
			x_start <= xs_q;
			y_start <= ys_q;
			x_end   <= vres.x;
			y_end   <= vres.y;
			xs_q    <= vres.x;
			ys_q    <= vres.y;
			k_q     <= k_q + 1'b1;
			ang_q   <= vangle;
		end
	end

endmodule

// ----- rtl/regular_polygon_edge_generator.sv -----
// ----------------------------------------------------------------------------
// regular_polygon_edge_generator
// Emits the edges of a regular polygon centred on the origin.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with sides while busy is low; the item is taken at that edge.
//   A count above MAX_SIDES saturates; a count of zero gives no segments.
//   The front divides out the angle step, one quotient bit a cycle, then
//   queues the job in a two-entry queue.
//   The back evaluates n+1 vertices in turn on one shared multiplier.
//   Each segment shows for one cycle with valid high; last marks the final one.
//   Results cannot be held off; none are ever dropped.
//   busy stays high while the front divides and until its job enters the queue,
//   which waits while the queue is full. The radius register sits at byte
//   address 0 of the APB port, reset 100. Reset empties the queue and returns all sequencers to idle.
// ----------------------------------------------------------------------------
module regular_polygon_edge_generator #(
	parameter int MAX_SIDES  = 64,
	parameter int ANGLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [rpeg_pkg::SIDE_W-1:0]         sides,
	output logic                                busy,
	output logic                                valid,
	output logic signed [rpeg_pkg::COORD_W-1:0] x_start,
	output logic signed [rpeg_pkg::COORD_W-1:0] y_start,
	output logic signed [rpeg_pkg::COORD_W-1:0] x_end,
	output logic signed [rpeg_pkg::COORD_W-1:0] y_end,
	output logic                                last,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rpeg_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import rpeg_pkg::*;

	localparam int JOB_W = SIDE_W + ANGLE_BITS;

	logic [RADIUS_W-1:0] radius_q;
	logic                push;
	logic                pop;
	logic                full;
	logic                empty;
	logic [JOB_W-1:0]    push_data;
	logic [JOB_W-1:0]    pop_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RADIUS) ? {24'd0, radius_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_RADIUS) begin
			radius_q <= pwdata[RADIUS_W-1:0];
		end
	end

	rpeg_front #(.MAX_SIDES(MAX_SIDES), .ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sides     (sides),
		.busy      (busy),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	rpeg_fifo #(.W(JOB_W)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	rpeg_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.radius   (radius_q),
		.empty    (empty),
		.pop      (pop),
		.pop_data (pop_data),
		.valid    (valid),
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.last     (last)
	);

endmodule

// ----- rtl/rpeg_checker.sv -----
// ----------------------------------------------------------------------------
// rpeg_checker
// Port-level assertions on the regular polygon edge generator.
// ----------------------------------------------------------------------------
module rpeg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic [rpeg_pkg::SIDE_W-1:0] sides,
	input logic                        busy,
	input logic                        valid,
	input logic                        last
);

	a_last_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!valid |-> !last)
		else $error("last without valid");

	a_take_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && sides != '0) |=> busy)
		else $error("item taken but front not busy");

	a_zero_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && sides == '0) |=> !busy)
		else $error("zero-side item made front busy");

	a_spaced_results: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid)
		else $error("results in adjacent cycles");

endmodule

bind regular_polygon_edge_generator rpeg_checker u_rpeg_checker (.*);
